FILE: hw/rtl/utf8d_pkg.sv
// Package for the UTF-8 stream decoder: field widths, byte class masks
// and result status codes. It has no dependencies.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 2;

    // Byte classes are told apart by a mask and a tag.
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    localparam logic [CNT_W-1:0] CNT_IDLE  = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 2'd3;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: byte input register, decode logic and
// code point result register. Depends on utf8d_pkg.
//
// Usage: one byte of UTF-8 text arrives per transfer on the s_ channel
// (s_tdata[7:0]). Each complete code point leaves as one transfer on the
// m_ channel: m_tdata[20:0] holds the code point, m_tuser the status
// (complete, truncated by a non-continuation byte, or invalid lead byte).
// Lead and middle continuation bytes produce no transfer of their own.
// The result register drives m_tvalid: an accepted byte is first
// captured in an input register, then decoded from that register
// and written into the result register. One byte is taken every cycle
// while the receiver keeps m_tready high. If the receiver stalls, the
// result register holds its transfer and the input register still takes
// one more byte; bytes that produce no result keep moving through the
// decoder during the stall. Reset (aresetn low, synchronous) empties both
// registers and closes any open sequence with a zero accumulator.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [CP_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg;
    logic [CP_W-1:0]   out_cp_reg;
    status_t           out_status_reg;

    logic              emit;
    logic [CP_W-1:0]   emit_cp;
    status_t           emit_status;
    logic [CP_W-1:0]   acc_shift;
    logic              advance;
    logic              out_free;
    logic              in_take;

    assign acc_shift = {acc_reg[CP_W-7:0], in_byte_reg[5:0]};

    always_comb begin
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        emit        = 1'b0;
        emit_cp     = '0;
        emit_status = ST_COMPLETE;
        if (cnt_reg != CNT_IDLE) begin
            if ((in_byte_reg & CONT_MASK) == CONT_TAG) begin
                acc_next = acc_shift;
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE) begin
                    emit    = 1'b1;
                    emit_cp = acc_shift;
                end
            end else begin
                // The breaking byte is dropped after the partial value goes out.
                cnt_next    = CNT_IDLE;
                emit        = 1'b1;
                emit_cp     = acc_reg;
                emit_status = ST_TRUNCATED;
            end
        end else begin
            priority if (!in_byte_reg[7]) begin
                emit    = 1'b1;
                emit_cp = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg};
            end else if ((in_byte_reg & LEAD2_MASK) == LEAD2_TAG) begin
                acc_next = {{(CP_W-5){1'b0}}, in_byte_reg[4:0]};
                cnt_next = CNT_ONE;
            end else if ((in_byte_reg & LEAD3_MASK) == LEAD3_TAG) begin
                acc_next = {{(CP_W-4){1'b0}}, in_byte_reg[3:0]};
                cnt_next = CNT_TWO;
            end else if ((in_byte_reg & LEAD4_MASK) == LEAD4_TAG) begin
                acc_next = {{(CP_W-3){1'b0}}, in_byte_reg[2:0]};
                cnt_next = CNT_THREE;
            end else begin
                emit        = 1'b1;
                emit_cp     = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg};
                emit_status = ST_INVALID;
            end
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !emit);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= CNT_IDLE;
        end else if (advance) begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_cp_reg     <= emit_cp;
            out_status_reg <= emit_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_cp_reg};
    assign m_tuser  = out_status_reg;

endmodule
